// File: hw/rtl/plsf_pkg.sv
// ----------------------------------------------------------------------------
// plsf_pkg
// shared types, constants and saturating arithmetic helpers for the
// polynomial least-squares fit core
// ----------------------------------------------------------------------------
package plsf_pkg;

	localparam int DEF_MAX_DEGREE  = 7;
	localparam int DEF_MAX_SAMPLES = 1024;

	localparam int SAMPLE_W     = 32;
	localparam int REG_W        = 64;
	localparam int DEGREE_W     = 3;
	localparam int COEF_IDX_W   = 3;
	localparam int DEGREE_RESET = 4;
	localparam int FRAC_W       = 16;

	localparam int IN_TDATA_W  = 64;
	localparam int OUT_TDATA_W = 40;

	localparam int QDEPTH = 4;
	localparam int QAW    = $clog2(QDEPTH);

	localparam logic signed [REG_W-1:0] Q_ONE   = 64'sd65536;
	localparam logic signed [REG_W-1:0] S64_MAX = 64'h7fff_ffff_ffff_ffff;
	localparam logic signed [REG_W-1:0] S64_MIN = 64'h8000_0000_0000_0000;
	localparam logic signed [REG_W-1:0] S32_MAX = 64'sh0000_0000_7fff_ffff;
	localparam logic signed [REG_W-1:0] S32_MIN = 64'shffff_ffff_8000_0000;

	typedef struct packed {
		logic signed [SAMPLE_W-1:0] x;
		logic signed [SAMPLE_W-1:0] y;
		logic                       last;
	} sample_t;

	// one request to a shared arithmetic unit
	typedef struct packed {
		logic                    start;
		logic signed [REG_W-1:0] a;
		logic signed [REG_W-1:0] b;
	} op_req_t;

	function automatic logic [REG_W-1:0] mag64(input logic signed [REG_W-1:0] v);
		return v[REG_W-1] ? (~v + 64'd1) : v;
	endfunction

	function automatic logic signed [REG_W-1:0] sat_add64(
		input logic signed [REG_W-1:0] a,
		input logic signed [REG_W-1:0] b
	);
		logic [REG_W:0] s;
		s = {a[REG_W-1], a} + {b[REG_W-1], b};
		if (s[REG_W] != s[REG_W-1])
			return s[REG_W] ? S64_MIN : S64_MAX;
		return s[REG_W-1:0];
	endfunction

	function automatic logic signed [REG_W-1:0] sat_sub64(
		input logic signed [REG_W-1:0] a,
		input logic signed [REG_W-1:0] b
	);
		logic [REG_W:0] s;
		s = {a[REG_W-1], a} - {b[REG_W-1], b};
		if (s[REG_W] != s[REG_W-1])
			return s[REG_W] ? S64_MIN : S64_MAX;
		return s[REG_W-1:0];
	endfunction

	function automatic logic signed [SAMPLE_W-1:0] sat32(input logic signed [REG_W-1:0] v);
		if (v > S32_MAX)
			return SAMPLE_W'(S32_MAX);
		if (v < S32_MIN)
			return SAMPLE_W'(S32_MIN);
		return v[SAMPLE_W-1:0];
	endfunction

endpackage

// File: hw/rtl/polynomial_least_squares_fit_core.sv
// ----------------------------------------------------------------------------
// polynomial_least_squares_fit_core
// least-squares polynomial fit over a stream of Q16.16 samples
// ----------------------------------------------------------------------------
// a sample takes one pass of both multipliers per power term,
// 15 terms at the default degree limit
// the solve after a last sample runs through the one divider and the
// multiplier for each matrix entry
// a four-deep input queue takes requests while the back end is busy
// asynchronous active-low reset clears sums, count and degree (4); no sweep
module polynomial_least_squares_fit_core import plsf_pkg::*; #(
	parameter int MAX_DEGREE  = DEF_MAX_DEGREE,
	parameter int MAX_SAMPLES = DEF_MAX_SAMPLES
) (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   s_tvalid,
	output logic                   s_tready,
	input  logic [IN_TDATA_W-1:0]  s_tdata,   // sample_x, sample_y
	input  logic                   s_tlast,   // last_sample
	output logic                   m_tvalid,
	input  logic                   m_tready,
	output logic [OUT_TDATA_W-1:0] m_tdata,   // coef_index, coef_value, zero pad
	output logic                   m_tuser,   // singular
	output logic                   m_tlast,   // last_coef
	input  logic                   cfg_valid,
	output logic                   cfg_ready,
	input  logic [DEGREE_W-1:0]    cfg_data   // degree
);

	logic [DEGREE_W-1:0]        degree_q;
	sample_t                    head;
	logic                       avail;
	logic                       pop;
	logic [COEF_IDX_W-1:0]      out_index;
	logic signed [SAMPLE_W-1:0] out_value;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			degree_q <= DEGREE_W'(DEGREE_RESET);
		else if (cfg_valid)
			degree_q <= cfg_data;
	end

	plsf_front u_front (
		.clk, .arst_n,
		.s_tvalid, .s_tready, .s_tdata, .s_tlast,
		.pop, .head, .avail
	);

	plsf_back #(
		.MAX_DEGREE (MAX_DEGREE),
		.MAX_SAMPLES(MAX_SAMPLES)
	) u_back (
		.clk, .arst_n,
		.degree      (degree_q),
		.head, .avail, .pop,
		.out_valid   (m_tvalid),
		.out_ready   (m_tready),
		.out_index   (out_index),
		.out_value   (out_value),
		.out_singular(m_tuser),
		.out_last    (m_tlast)
	);

	assign m_tdata = {{(OUT_TDATA_W - COEF_IDX_W - SAMPLE_W){1'b0}}, out_value, out_index};

endmodule

// File: hw/rtl/plsf_front.sv
// ----------------------------------------------------------------------------
// plsf_front
// input side: takes sample requests and holds them in a short queue for the
// back end, so the stream can keep moving while the back end is busy
// ----------------------------------------------------------------------------
module plsf_front import plsf_pkg::*; (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  s_tvalid,
	output logic                  s_tready,
	input  logic [IN_TDATA_W-1:0] s_tdata,  // sample_x, sample_y
	input  logic                  s_tlast,  // last_sample
	input  logic                  pop,
	output sample_t               head,
	output logic                  avail
);

	sample_t        slot_q [QDEPTH];
	logic [QAW-1:0] wr_q;
	logic [QAW-1:0] rd_q;
	logic [QAW:0]   cnt_q;
	logic           push;
	logic           take;

	assign s_tready = (cnt_q != (QAW+1)'(QDEPTH));
	assign avail    = (cnt_q != '0);
	assign push     = s_tvalid && s_tready;
	assign take     = pop && avail;
	assign head     = slot_q[rd_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q  <= '0;
			rd_q  <= '0;
			cnt_q <= '0;
		end else begin
			if (push)
				wr_q <= wr_q + QAW'(1);
			if (take)
				rd_q <= rd_q + QAW'(1);
			if (push && !take)
				cnt_q <= cnt_q + (QAW+1)'(1);
			else if (take && !push)
				cnt_q <= cnt_q - (QAW+1)'(1);
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			slot_q[wr_q].x    <= s_tdata[SAMPLE_W-1:0];
			slot_q[wr_q].y    <= s_tdata[2*SAMPLE_W-1:SAMPLE_W];
			slot_q[wr_q].last <= s_tlast;
		end
	end

endmodule

// File: hw/rtl/plsf_qmul.sv
// ----------------------------------------------------------------------------
// plsf_qmul
// Q48.16 saturating multiplier, four 32x32 partial products in turn
// ----------------------------------------------------------------------------
module plsf_qmul import plsf_pkg::*; (
	input  logic                    clk,
	input  logic                    arst_n,
	input  op_req_t                 req,
	output logic signed [REG_W-1:0] res,
	output logic                    done
);

	logic [REG_W-1:0]   ma_q;
	logic [REG_W-1:0]   mb_q;
	logic               neg_q;
	logic [2*REG_W-1:0] acc_q;
	logic [REG_W-1:0]   pp_q;
	logic [2:0]         st_q;
	logic signed [REG_W-1:0] res_q;
	logic               done_q;
	logic               big;

	assign res  = res_q;
	assign done = done_q;
	assign big  = |acc_q[2*REG_W-1:REG_W+FRAC_W-1];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q   <= '0;
			done_q <= 1'b0;
		end else begin
			done_q <= (st_q == 3'd6);
			if (req.start)
				st_q <= 3'd1;
			else if (st_q == 3'd6)
				st_q <= '0;
			else if (st_q != '0)
				st_q <= st_q + 3'd1;
		end
	end

	always_ff @(posedge clk) begin
		if (req.start) begin
			ma_q  <= mag64(req.a);
			mb_q  <= mag64(req.b);
			neg_q <= req.a[REG_W-1] ^ req.b[REG_W-1];
			acc_q <= '0;
		end else begin
			case (st_q)
				3'd1: pp_q <= 64'(ma_q[31:0]) * 64'(mb_q[31:0]);
				3'd2: begin
					acc_q <= acc_q + {64'd0, pp_q};
					pp_q  <= 64'(ma_q[31:0]) * 64'(mb_q[63:32]);
				end
				3'd3: begin
					acc_q <= acc_q + {32'd0, pp_q, 32'd0};
					pp_q  <= 64'(ma_q[63:32]) * 64'(mb_q[31:0]);
				end
				3'd4: begin
					acc_q <= acc_q + {32'd0, pp_q, 32'd0};
					pp_q  <= 64'(ma_q[63:32]) * 64'(mb_q[63:32]);
				end
				3'd5: acc_q <= acc_q + {pp_q, 64'd0};
				3'd6: begin
					if (neg_q)
						res_q <= big ? S64_MIN : -$signed({1'b0, acc_q[REG_W+FRAC_W-2:FRAC_W]});
					else
						res_q <= big ? S64_MAX : $signed({1'b0, acc_q[REG_W+FRAC_W-2:FRAC_W]});
				end
				default: ;
			endcase
		end
	end

endmodule

// File: hw/rtl/plsf_qdiv.sv
// ----------------------------------------------------------------------------
// plsf_qdiv
// Q48.16 saturating divider, restoring, one quotient bit per cycle
// ----------------------------------------------------------------------------
module plsf_qdiv import plsf_pkg::*; (
	input  logic                    clk,
	input  logic                    arst_n,
	input  op_req_t                 req,
	output logic signed [REG_W-1:0] res,
	output logic                    done
);

	localparam int NUM_W = REG_W + FRAC_W;
	localparam int CNT_W = $clog2(NUM_W + 2);

	logic [NUM_W-1:0] nq_q;   // numerator shifting out, quotient shifting in
	logic [REG_W:0]   rem_q;
	logic [REG_W-1:0] d_q;
	logic             neg_q;
	logic             zero_q;
	logic signed [REG_W-1:0] zres_q;
	logic [CNT_W-1:0] cnt_q;
	logic             busy_q;
	logic signed [REG_W-1:0] res_q;
	logic             done_q;
	logic [REG_W:0]   rsh;
	logic             ge;
	logic             big;

	assign rsh  = {rem_q[REG_W-1:0], nq_q[NUM_W-1]};
	assign ge   = (rsh >= {1'b0, d_q});
	assign big  = |nq_q[NUM_W-1:REG_W-1];
	assign res  = res_q;
	assign done = done_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			cnt_q  <= '0;
			done_q <= 1'b0;
		end else begin
			done_q <= 1'b0;
			if (req.start) begin
				busy_q <= 1'b1;
				cnt_q  <= '0;
			end else if (busy_q) begin
				if (zero_q || cnt_q == CNT_W'(NUM_W)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end else
					cnt_q <= cnt_q + CNT_W'(1);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (req.start) begin
			nq_q   <= {mag64(req.a), {FRAC_W{1'b0}}};
			d_q    <= mag64(req.b);
			rem_q  <= '0;
			neg_q  <= req.a[REG_W-1] ^ req.b[REG_W-1];
			zero_q <= (req.b == '0);
			if (req.a == '0)
				zres_q <= '0;
			else
				zres_q <= req.a[REG_W-1] ? S64_MIN : S64_MAX;
		end else if (busy_q) begin
			if (zero_q)
				res_q <= zres_q;
			else if (cnt_q == CNT_W'(NUM_W)) begin
				if (neg_q)
					res_q <= big ? S64_MIN : -$signed({1'b0, nq_q[REG_W-2:0]});
				else
					res_q <= big ? S64_MAX : $signed({1'b0, nq_q[REG_W-2:0]});
			end else begin
				rem_q <= ge ? (rsh - {1'b0, d_q}) : rsh;
				nq_q  <= {nq_q[NUM_W-2:0], ge};
			end
		end
	end

endmodule

// File: hw/rtl/plsf_back.sv
// ----------------------------------------------------------------------------
// plsf_back
// back end: accumulates power and cross sums per sample, then on the last
// sample solves the normal equations by gauss-jordan and emits coefficients
// ----------------------------------------------------------------------------
module plsf_back import plsf_pkg::*; #(
	parameter int MAX_DEGREE  = DEF_MAX_DEGREE,
	parameter int MAX_SAMPLES = DEF_MAX_SAMPLES
) (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic [DEGREE_W-1:0]        degree,
	input  sample_t                    head,
	input  logic                       avail,
	output logic                       pop,
	output logic                       out_valid,
	input  logic                       out_ready,
	output logic [COEF_IDX_W-1:0]      out_index,
	output logic signed [SAMPLE_W-1:0] out_value,
	output logic                       out_singular,
	output logic                       out_last
);

	localparam int ORD  = MAX_DEGREE + 1;
	localparam int NPOW = 2 * MAX_DEGREE + 1;
	localparam int DW   = $clog2(ORD);
	localparam int CW   = $clog2(2 * ORD);
	localparam int PW   = $clog2(NPOW);
	localparam int OW   = $clog2(ORD + 1);
	localparam int SCW  = $clog2(MAX_SAMPLES + 1);
	localparam int AW   = DW + CW;

	typedef enum logic [4:0] {
		S_IDLE, S_ACC_MUL, S_ACC_WAIT, S_LOAD, S_PIV_RD, S_PIV_CHK,
		S_ROW_SEL, S_ROW_NEXT, S_ROW_RD, S_ROW_DIV, S_ROW_WAIT,
		S_EL_RD, S_EL_CHK, S_EL_WAIT, S_EL_NEXT,
		S_FD_RD, S_FD_DIV, S_FD_WAIT,
		S_CO_RD, S_CO_MUL, S_CO_WAIT, S_EMIT, S_CLEAR
	} state_t;

	state_t state_q;

	logic signed [REG_W-1:0] ps_q [NPOW];
	logic signed [REG_W-1:0] cs_q [ORD];
	logic [SCW-1:0]          cnt_q;

	logic signed [REG_W-1:0] wm [2**AW];
	logic signed [REG_W-1:0] rd_a;
	logic signed [REG_W-1:0] rd_b;
	logic [AW-1:0]           addr_a;
	logic [AW-1:0]           addr_b;
	logic                    we;
	logic [AW-1:0]           waddr;
	logic signed [REG_W-1:0] wdata;

	logic [DW-1:0] i_q;
	logic [DW-1:0] j_q;
	logic [CW-1:0] k_q;
	logic [PW-1:0] kp_q;
	logic [OW-1:0] order_q;

	logic signed [SAMPLE_W-1:0] x_q;
	logic signed [SAMPLE_W-1:0] y_q;
	logic                       last_q;
	logic signed [REG_W-1:0]    p_q;
	logic signed [REG_W-1:0]    piv_q;
	logic signed [REG_W-1:0]    ratio_q;
	logic signed [REG_W-1:0]    wjk_q;
	logic signed [REG_W-1:0]    acc_q;

	logic [COEF_IDX_W-1:0]      em_idx_q;
	logic signed [SAMPLE_W-1:0] em_val_q;
	logic                       em_sing_q;
	logic                       em_last_q;

	logic                       ov_q;
	logic [COEF_IDX_W-1:0]      o_idx_q;
	logic signed [SAMPLE_W-1:0] o_val_q;
	logic                       o_sing_q;
	logic                       o_last_q;
	logic                       emit_go;

	op_req_t mreq_a;
	op_req_t mreq_b;
	op_req_t dreq;
	logic signed [REG_W-1:0] mres_a;
	logic signed [REG_W-1:0] mres_b;
	logic signed [REG_W-1:0] dres;
	logic                    mdone_a;
	logic                    mdone_b;
	logic                    ddone;

	logic [DW-1:0]           ord_m1;
	logic [CW-1:0]           ord_col;
	logic [CW-1:0]           col_last;
	logic [PW-1:0]           ps_idx;
	logic [DW-1:0]           cs_idx;
	logic signed [REG_W-1:0] ps_rd;
	logic signed [REG_W-1:0] cs_rd;
	logic signed [REG_W-1:0] load_val;
	logic signed [REG_W-1:0] acc_nx;
	logic signed [REG_W-1:0] x_ext;
	logic signed [REG_W-1:0] y_ext;

	plsf_qmul u_mul_a (.clk, .arst_n, .req(mreq_a), .res(mres_a), .done(mdone_a));
	plsf_qmul u_mul_b (.clk, .arst_n, .req(mreq_b), .res(mres_b), .done(mdone_b));
	plsf_qdiv u_div   (.clk, .arst_n, .req(dreq),   .res(dres),   .done(ddone));

	assign ord_m1   = DW'(order_q - OW'(1));
	assign ord_col  = CW'(order_q);
	assign col_last = CW'({order_q, 1'b0} - (OW+1)'(1));
	assign x_ext    = REG_W'(x_q);
	assign y_ext    = REG_W'(y_q);

	assign ps_idx = (state_q == S_LOAD) ? (PW'(i_q) + PW'(k_q)) : kp_q;
	assign cs_idx = (state_q == S_ACC_WAIT) ? DW'(kp_q) : DW'(k_q);
	assign ps_rd  = ps_q[ps_idx];
	assign cs_rd  = cs_q[cs_idx];
	assign acc_nx = sat_add64(acc_q, mres_a);

	always_comb begin
		if (k_q < ord_col)
			load_val = ps_rd;
		else if ((k_q - ord_col) == CW'(i_q))
			load_val = Q_ONE;
		else
			load_val = '0;
	end

	// matrix addressing per phase
	always_comb begin
		addr_a = {i_q, k_q};
		addr_b = {i_q, k_q};
		we     = 1'b0;
		waddr  = {i_q, k_q};
		wdata  = '0;
		unique case (state_q)
			S_PIV_RD, S_PIV_CHK: addr_a = {i_q, CW'(i_q)};
			S_ROW_RD, S_ROW_DIV: addr_a = {j_q, CW'(i_q)};
			S_EL_RD, S_EL_CHK:   addr_a = {j_q, k_q};
			S_FD_RD, S_FD_DIV:   addr_b = {i_q, CW'(i_q)};
			S_CO_RD, S_CO_MUL:   addr_a = {i_q, ord_col + k_q};
			default: ;
		endcase
		unique case (state_q)
			S_LOAD: begin
				we    = 1'b1;
				wdata = load_val;
			end
			S_EL_CHK: begin
				we    = (k_q == CW'(i_q));
				waddr = {j_q, k_q};
			end
			S_EL_WAIT: begin
				we    = mdone_a;
				waddr = {j_q, k_q};
				wdata = sat_sub64(wjk_q, mres_a);
			end
			S_FD_WAIT: begin
				we    = ddone;
				wdata = dres;
			end
			default: ;
		endcase
	end

	always_comb begin
		mreq_a = '0;
		mreq_b = '0;
		dreq   = '0;
		unique case (state_q)
			S_ACC_MUL: begin
				mreq_a = '{start: 1'b1, a: p_q, b: x_ext};
				mreq_b = '{start: 1'b1, a: y_ext, b: p_q};
			end
			S_EL_CHK:  mreq_a = '{start: (k_q != CW'(i_q)), a: ratio_q, b: rd_b};
			S_CO_MUL:  mreq_a = '{start: 1'b1, a: rd_a, b: cs_rd};
			S_ROW_DIV: dreq   = '{start: 1'b1, a: rd_a, b: piv_q};
			S_FD_DIV:  dreq   = '{start: 1'b1, a: rd_a, b: rd_b};
			default: ;
		endcase
	end

	always_ff @(posedge clk) begin
		if (we)
			wm[waddr] <= wdata;
		rd_a <= wm[addr_a];
		rd_b <= wm[addr_b];
	end

	assign pop          = (state_q == S_IDLE) && avail;
	assign emit_go      = (state_q == S_EMIT) && (!ov_q || out_ready);
	assign out_valid    = ov_q;
	assign out_index    = o_idx_q;
	assign out_value    = o_val_q;
	assign out_singular = o_sing_q;
	assign out_last     = o_last_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			cnt_q   <= '0;
			ov_q    <= 1'b0;
			for (int n = 0; n < NPOW; n++)
				ps_q[n] <= '0;
			for (int n = 0; n < ORD; n++)
				cs_q[n] <= '0;
		end else begin
			if (emit_go)
				ov_q <= 1'b1;
			else if (out_ready)
				ov_q <= 1'b0;
			unique case (state_q)
				S_IDLE: begin
					if (avail) begin
						x_q    <= head.x;
						y_q    <= head.y;
						last_q <= head.last;
						if (cnt_q < SCW'(MAX_SAMPLES)) begin
							cnt_q   <= cnt_q + SCW'(1);
							kp_q    <= '0;
							p_q     <= Q_ONE;
							state_q <= S_ACC_MUL;
						end else if (head.last) begin
							i_q     <= '0;
							k_q     <= '0;
							state_q <= S_LOAD;
						end
						if (int'(degree) > MAX_DEGREE)
							order_q <= OW'(ORD);
						else
							order_q <= OW'(degree) + OW'(1);
					end
				end
				S_ACC_MUL: begin
					ps_q[kp_q] <= sat_add64(ps_q[kp_q], p_q);
					state_q    <= S_ACC_WAIT;
				end
				S_ACC_WAIT: begin
					if (mdone_a && mdone_b) begin
						if (kp_q < PW'(ORD))
							cs_q[cs_idx] <= sat_add64(cs_rd, mres_b);
						p_q <= mres_a;
						if (kp_q == PW'(NPOW - 1)) begin
							i_q     <= '0;
							k_q     <= '0;
							state_q <= last_q ? S_LOAD : S_IDLE;
						end else begin
							kp_q    <= kp_q + PW'(1);
							state_q <= S_ACC_MUL;
						end
					end
				end
				S_LOAD: begin
					if (k_q == col_last) begin
						k_q <= '0;
						if (i_q == ord_m1) begin
							i_q     <= '0;
							state_q <= S_PIV_RD;
						end else
							i_q <= i_q + DW'(1);
					end else
						k_q <= k_q + CW'(1);
				end
				S_PIV_RD: state_q <= S_PIV_CHK;
				S_PIV_CHK: begin
					piv_q <= rd_a;
					j_q   <= '0;
					if (rd_a == '0) begin
						em_idx_q  <= '0;
						em_val_q  <= '0;
						em_sing_q <= 1'b1;
						em_last_q <= 1'b1;
						state_q   <= S_EMIT;
					end else
						state_q <= S_ROW_SEL;
				end
				S_ROW_SEL: state_q <= (j_q == i_q) ? S_ROW_NEXT : S_ROW_RD;
				S_ROW_NEXT: begin
					if (j_q == ord_m1) begin
						if (i_q == ord_m1) begin
							i_q     <= '0;
							k_q     <= ord_col;
							state_q <= S_FD_RD;
						end else begin
							i_q     <= i_q + DW'(1);
							state_q <= S_PIV_RD;
						end
					end else begin
						j_q     <= j_q + DW'(1);
						state_q <= S_ROW_SEL;
					end
				end
				S_ROW_RD:  state_q <= S_ROW_DIV;
				S_ROW_DIV: state_q <= S_ROW_WAIT;
				S_ROW_WAIT: begin
					if (ddone) begin
						ratio_q <= dres;
						k_q     <= '0;
						state_q <= S_EL_RD;
					end
				end
				S_EL_RD: state_q <= S_EL_CHK;
				S_EL_CHK: begin
					wjk_q   <= rd_a;
					// the pivot column of a non-pivot row is forced to zero
					state_q <= (k_q == CW'(i_q)) ? S_EL_NEXT : S_EL_WAIT;
				end
				S_EL_WAIT: begin
					if (mdone_a)
						state_q <= S_EL_NEXT;
				end
				S_EL_NEXT: begin
					if (k_q == col_last)
						state_q <= S_ROW_NEXT;
					else begin
						k_q     <= k_q + CW'(1);
						state_q <= S_EL_RD;
					end
				end
				S_FD_RD:  state_q <= S_FD_DIV;
				S_FD_DIV: state_q <= S_FD_WAIT;
				S_FD_WAIT: begin
					if (ddone) begin
						if (k_q == col_last) begin
							if (i_q == ord_m1) begin
								i_q     <= '0;
								k_q     <= '0;
								acc_q   <= '0;
								state_q <= S_CO_RD;
							end else begin
								i_q     <= i_q + DW'(1);
								k_q     <= ord_col;
								state_q <= S_FD_RD;
							end
						end else begin
							k_q     <= k_q + CW'(1);
							state_q <= S_FD_RD;
						end
					end
				end
				S_CO_RD:  state_q <= S_CO_MUL;
				S_CO_MUL: state_q <= S_CO_WAIT;
				S_CO_WAIT: begin
					if (mdone_a) begin
						acc_q <= acc_nx;
						if (k_q == CW'(ord_m1)) begin
							em_idx_q  <= COEF_IDX_W'(i_q);
							em_val_q  <= sat32(acc_nx);
							em_sing_q <= 1'b0;
							em_last_q <= (i_q == ord_m1);
							state_q   <= S_EMIT;
						end else begin
							k_q     <= k_q + CW'(1);
							state_q <= S_CO_RD;
						end
					end
				end
				S_EMIT: begin
					if (emit_go) begin
						o_idx_q  <= em_idx_q;
						o_val_q  <= em_val_q;
						o_sing_q <= em_sing_q;
						o_last_q <= em_last_q;
						if (em_last_q)
							state_q <= S_CLEAR;
						else begin
							i_q     <= i_q + DW'(1);
							k_q     <= '0;
							acc_q   <= '0;
							state_q <= S_CO_RD;
						end
					end
				end
				S_CLEAR: begin
					for (int n = 0; n < NPOW; n++)
						ps_q[n] <= '0;
					for (int n = 0; n < ORD; n++)
						cs_q[n] <= '0;
					cnt_q   <= '0;
					state_q <= S_IDLE;
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

endmodule

// File: tb/polynomial_least_squares_fit_core_checker.sv
// ----------------------------------------------------------------------------
// polynomial_least_squares_fit_core_checker
// watches the sample, coefficient and degree channels, keeps its own
// accumulation sums and solves the normal equations on every last sample,
// then compares each coefficient request with the oldest predicted one
// ----------------------------------------------------------------------------
module polynomial_least_squares_fit_core_checker import plsf_pkg::*; (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   s_tvalid,
	input  logic                   s_tready,
	input  logic [IN_TDATA_W-1:0]  s_tdata,   // sample_x, sample_y
	input  logic                   s_tlast,   // last_sample
	input  logic                   m_tvalid,
	input  logic                   m_tready,
	input  logic [OUT_TDATA_W-1:0] m_tdata,   // coef_index, coef_value, zero pad
	input  logic                   m_tuser,   // singular
	input  logic                   m_tlast,   // last_coef
	input  logic                   cfg_valid,
	input  logic                   cfg_ready,
	input  logic [DEGREE_W-1:0]    cfg_data,  // degree
	output int                     fails,
	output int                     pending
);

	localparam int ORDER_MAX = DEF_MAX_DEGREE + 1;
	localparam int NUM_POW   = 2 * DEF_MAX_DEGREE + 1;
	localparam logic [127:0] LIM63 = 128'h8000_0000_0000_0000;

	typedef struct packed {
		logic [COEF_IDX_W-1:0]      idx;
		logic signed [SAMPLE_W-1:0] val;
		logic                       sing;
		logic                       last;
	} coef_t;

	longint            pow_acc[NUM_POW];
	longint            xy_acc[ORDER_MAX];
	int                n_acc;
	logic [DEGREE_W-1:0] fit_degree;
	coef_t             coef_q[$];

	function automatic logic [63:0] absval(longint v);
		return v < 0 ? 64'(-v) : 64'(v);
	endfunction

	function automatic longint clip64(logic neg, logic [127:0] u);
		if (neg)
			return (u >= LIM63) ? S64_MIN : -longint'(u[63:0]);
		return (u >= LIM63) ? S64_MAX : longint'(u[63:0]);
	endfunction

	function automatic longint qmul(longint a, longint b);
		logic [127:0] p;
		p = {64'd0, absval(a)} * {64'd0, absval(b)};
		return clip64((a < 0) != (b < 0), p >> FRAC_W);
	endfunction

	function automatic longint qdiv(longint a, longint b);
		logic [127:0] q;
		if (b == 0)
			return a == 0 ? 64'sd0 : (a < 0 ? S64_MIN : S64_MAX);
		q = ({64'd0, absval(a)} << FRAC_W) / {64'd0, absval(b)};
		return clip64((a < 0) != (b < 0), q);
	endfunction

	function automatic longint addc(longint a, longint b);
		logic signed [64:0] s;
		s = 65'(a) + 65'(b);
		if (s > 65'(S64_MAX))
			return S64_MAX;
		if (s < 65'(S64_MIN))
			return S64_MIN;
		return longint'(s[63:0]);
	endfunction

	function automatic longint subc(longint a, longint b);
		logic signed [64:0] s;
		s = 65'(a) - 65'(b);
		if (s > 65'(S64_MAX))
			return S64_MAX;
		if (s < 65'(S64_MIN))
			return S64_MIN;
		return longint'(s[63:0]);
	endfunction

	function automatic void accumulate(longint x, longint y);
		longint p;
		p = Q_ONE;
		for (int k = 0; k < NUM_POW; k++) begin
			if (k > 0)
				p = qmul(p, x);
			pow_acc[k] = addc(pow_acc[k], p);
			if (k < ORDER_MAX)
				xy_acc[k] = addc(xy_acc[k], qmul(y, p));
		end
		n_acc++;
	endfunction

	// gauss-jordan on [X'X | I], no pivot search, then inverse times X'Y
	function automatic void solve_fit();
		longint m[ORDER_MAX][2*ORDER_MAX];
		longint piv, ratio, acc;
		int ord;
		coef_t c;
		ord = int'(fit_degree) > DEF_MAX_DEGREE ? DEF_MAX_DEGREE + 1 : int'(fit_degree) + 1;
		for (int i = 0; i < ord; i++)
			for (int j = 0; j < ord; j++) begin
				m[i][j] = pow_acc[i+j];
				m[i][ord+j] = (i == j) ? Q_ONE : 64'sd0;
			end
		for (int i = 0; i < ord; i++) begin
			piv = m[i][i];
			if (piv == 0) begin
				c = '{idx: '0, val: '0, sing: 1'b1, last: 1'b1};
				coef_q.push_back(c);
				return;
			end
			for (int j = 0; j < ord; j++) begin
				if (j != i) begin
					ratio = qdiv(m[j][i], piv);
					for (int k = 0; k < 2*ord; k++)
						m[j][k] = (k == i) ? 64'sd0 : subc(m[j][k], qmul(ratio, m[i][k]));
				end
			end
		end
		for (int i = 0; i < ord; i++)
			for (int j = ord; j < 2*ord; j++)
				m[i][j] = qdiv(m[i][j], m[i][i]);
		for (int i = 0; i < ord; i++) begin
			acc = 0;
			for (int k = 0; k < ord; k++)
				acc = addc(acc, qmul(m[i][ord+k], xy_acc[k]));
			if (acc > S32_MAX)
				acc = S32_MAX;
			if (acc < S32_MIN)
				acc = S32_MIN;
			c.idx  = COEF_IDX_W'(i);
			c.val  = acc[SAMPLE_W-1:0];
			c.sing = 1'b0;
			c.last = (i == ord - 1);
			coef_q.push_back(c);
		end
	endfunction

	assign pending = coef_q.size();

	always @(posedge clk or negedge arst_n) begin
		coef_t got, want;
		if (!arst_n) begin
			foreach (pow_acc[k]) pow_acc[k] = 0;
			foreach (xy_acc[k]) xy_acc[k] = 0;
			n_acc      = 0;
			fit_degree = DEGREE_W'(DEGREE_RESET);
			fails      = 0;
			coef_q.delete();
		end else begin
			if (m_tvalid && m_tready) begin
				got = '{idx: m_tdata[COEF_IDX_W-1:0],
					val: m_tdata[COEF_IDX_W +: SAMPLE_W], sing: m_tuser, last: m_tlast};
				if (coef_q.size() == 0) begin
					fails++;
					if (fails < 100)
						$display("%0t: unexpected coefficient request, expected none, got %h",
							$time, got);
				end else begin
					want = coef_q.pop_front();
					if (got !== want) begin
						fails++;
						if (fails < 100)
							$display("%0t: coefficient mismatch, expected %h, got %h",
								$time, want, got);
					end
				end
			end
			if (cfg_valid && cfg_ready)
				fit_degree = cfg_data;
			if (s_tvalid && s_tready) begin
				if (n_acc < DEF_MAX_SAMPLES)
					accumulate(longint'($signed(s_tdata[31:0])),
						longint'($signed(s_tdata[63:32])));
				if (s_tlast) begin
					solve_fit();
					foreach (pow_acc[k]) pow_acc[k] = 0;
					foreach (xy_acc[k]) xy_acc[k] = 0;
					n_acc = 0;
				end
			end
		end
	end

endmodule

// File: tb/polynomial_least_squares_fit_core_tb.sv
// ----------------------------------------------------------------------------
// polynomial_least_squares_fit_core_tb
// drives sample runs at several degrees and idle/stall mixes into the fit
// core; a checker beside it predicts and compares every coefficient
// ----------------------------------------------------------------------------
module polynomial_least_squares_fit_core_tb;
	import plsf_pkg::*;

	localparam longint CYCLE_LIMIT = 64'd8_000_000;
	localparam int     HOLD_LEN    = 4000;

	logic                   clk;
	logic                   arst_n;
	logic                   s_tvalid;
	logic                   s_tready;
	logic [IN_TDATA_W-1:0]  s_tdata;   // sample_x, sample_y
	logic                   s_tlast;   // last_sample
	logic                   m_tvalid;
	logic                   m_tready;
	logic [OUT_TDATA_W-1:0] m_tdata;   // coef_index, coef_value, zero pad
	logic                   m_tuser;   // singular
	logic                   m_tlast;   // last_coef
	logic                   cfg_valid;
	logic                   cfg_ready;
	logic [DEGREE_W-1:0]    cfg_data;  // degree

	int     fails, pending;
	int     send_idle_pct, recv_stall_pct;
	logic   hold_trig, hold_seen;
	int     hold_left;
	longint cycles = 0;

	polynomial_least_squares_fit_core u_dut (
		.clk, .arst_n,
		.s_tvalid, .s_tready, .s_tdata, .s_tlast,
		.m_tvalid, .m_tready, .m_tdata, .m_tuser, .m_tlast,
		.cfg_valid, .cfg_ready, .cfg_data
	);

	polynomial_least_squares_fit_core_checker u_checker (
		.clk, .arst_n,
		.s_tvalid, .s_tready, .s_tdata, .s_tlast,
		.m_tvalid, .m_tready, .m_tdata, .m_tuser, .m_tlast,
		.cfg_valid, .cfg_ready, .cfg_data,
		.fails, .pending
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles > CYCLE_LIMIT) begin
			$display("Mismatches found");
			$finish;
		end
	end

	// receiver: random stalls plus one long hold-off
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_tready  <= 1'b0;
			hold_left <= 0;
			hold_seen <= 1'b0;
		end else if (hold_trig != hold_seen) begin
			hold_seen <= hold_trig;
			hold_left <= HOLD_LEN;
			m_tready  <= 1'b0;
		end else if (hold_left > 0) begin
			hold_left <= hold_left - 1;
			m_tready  <= 1'b0;
		end else begin
			m_tready <= ($urandom_range(99) >= recv_stall_pct);
		end
	end

	task automatic put_sample(logic [31:0] x, logic [31:0] y, logic last);
		if ($urandom_range(99) < send_idle_pct) begin
			s_tvalid <= 1'b0;
			repeat ($urandom_range(1, 4)) @(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata  <= {y, x};
		s_tlast  <= last;
		do @(posedge clk); while (!s_tready);
	endtask

	task automatic drain();
		s_tvalid <= 1'b0;
		@(posedge clk);
		while (pending != 0) @(posedge clk);
		// a mid-run sample may still be accumulating
		repeat (300) @(posedge clk);
	endtask

	task automatic set_degree(logic [DEGREE_W-1:0] d);
		cfg_valid <= 1'b1;
		cfg_data  <= d;
		do @(posedge clk); while (!cfg_ready);
		cfg_valid <= 1'b0;
	endtask

	function automatic logic [31:0] pick_x();
		case ($urandom_range(9))
			0:       return $urandom;
			8, 9:    return 32'($signed($urandom_range(0, 16)) - 8) << 16;
			default: return 32'($signed($urandom_range(0, 524288)) - 262144);
		endcase
	endfunction

	function automatic logic [31:0] pick_y();
		if ($urandom_range(4) == 0)
			return $urandom;
		return 32'($signed($urandom_range(0, 13107200)) - 6553600);
	endfunction

	task automatic random_run(int len);
		for (int i = 0; i < len; i++)
			put_sample(pick_x(), pick_y(), i == len - 1);
	endtask

	initial begin
		int idle_tab[4];
		int stall_tab[4];
		logic [DEGREE_W-1:0] deg_tab[4];
		int sent;
		idle_tab       = '{0, 61, 0, 15};
		stall_tab      = '{0, 0, 61, 15};
		deg_tab        = '{3'd2, 3'd7, 3'd1, 3'd3};
		arst_n         = 1'b0;
		s_tvalid       = 1'b0;
		s_tdata        = '0;
		s_tlast        = 1'b0;
		cfg_valid      = 1'b0;
		cfg_data       = '0;
		hold_trig      = 1'b0;
		send_idle_pct  = 0;
		recv_stall_pct = 0;
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// reset degree: exact quadratic through five points
		for (int i = -2; i <= 2; i++)
			put_sample(32'(i) << 16, 32'(3 + 2*i*i - i) << 16, i == 2);
		// field extremes, saturating sums
		put_sample(32'h7fff_ffff, 32'h7fff_ffff, 1'b0);
		put_sample(32'h8000_0000, 32'h8000_0000, 1'b0);
		put_sample(32'h0000_0000, 32'h7fff_ffff, 1'b0);
		put_sample(32'hffff_ffff, 32'h8000_0000, 1'b0);
		put_sample(32'h0000_0001, 32'h0000_0000, 1'b1);
		// zero pivot: every x is zero
		put_sample(32'd0, 32'h0001_0000, 1'b0);
		put_sample(32'd0, 32'h0002_0000, 1'b0);
		put_sample(32'd0, 32'h0003_0000, 1'b1);
		drain();
		set_degree(3'd0);
		put_sample(32'h7fff_ffff, 32'h8000_0000, 1'b1);
		put_sample(32'h8000_0000, 32'h7fff_ffff, 1'b1);
		put_sample(32'h0003_0000, 32'h0005_0000, 1'b0);
		put_sample(32'hfffd_0000, 32'hfffb_0000, 1'b1);
		drain();
		set_degree(3'd7);
		put_sample(32'h0001_0000, 32'h0001_0000, 1'b1);
		for (int i = 0; i < 9; i++)
			put_sample(32'(i - 4) << 15, pick_y(), i == 8);
		drain();

		// sample cap: more than the count limit in one run, cheap solve
		set_degree(3'd0);
		for (int i = 0; i < DEF_MAX_SAMPLES + 6; i++)
			put_sample(pick_x(), pick_y(), i == DEF_MAX_SAMPLES + 5);
		drain();

		for (int ph = 0; ph < 4; ph++) begin
			set_degree(ph == 3 ? 3'($urandom_range(0, 7)) : deg_tab[ph]);
			send_idle_pct  = idle_tab[ph];
			recv_stall_pct = stall_tab[ph];
			if (ph == 0) begin
				// long receiver hold-off while short runs keep coming
				hold_trig <= ~hold_trig;
				for (int r = 0; r < 4; r++)
					random_run(2);
			end
			sent = 0;
			while (sent < 50) begin
				int len;
				len = ($urandom_range(9) == 0) ? $urandom_range(1, 3) : $urandom_range(4, 12);
				random_run(len);
				sent += len;
			end
			drain();
		end

		if (fails == 0) begin
			$display("No mismatches found");
		end else begin
			$display("Mismatches found");
		end
		$finish;
	end

endmodule

// File: sim.f
hw/rtl/plsf_pkg.sv
hw/rtl/plsf_front.sv
hw/rtl/plsf_qmul.sv
hw/rtl/plsf_qdiv.sv
hw/rtl/plsf_back.sv
hw/rtl/polynomial_least_squares_fit_core.sv
tb/polynomial_least_squares_fit_core_checker.sv
tb/polynomial_least_squares_fit_core_tb.sv
